// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== rtl/lie_pkg.sv =====
// ----------------------------------------------------------------------------
// lie_pkg
// Types, codes and opcode fields of the logic instruction execute unit.
// ----------------------------------------------------------------------------
package lie_pkg;

  localparam int NUM_REGS  = 16;
  localparam int REG_IDX_W = 4;
  localparam int DATA_W    = 32;

  // Command codes
  localparam logic [1:0] CMD_EXEC     = 2'd0;
  localparam logic [1:0] CMD_LOAD_REG = 2'd1;
  localparam logic [1:0] CMD_LOAD_PC  = 2'd2;

  // Opcode fields
  localparam logic [3:0] TOP_REG_LOGIC = 4'h2;
  localparam logic [3:0] TOP_NOT       = 4'h6;
  localparam logic [3:0] LOW_NOT       = 4'h7;
  localparam logic [3:0] TOP_IMM       = 4'hC;
  localparam logic [1:0] HI_IMM_GROUP  = 2'b10;   // bits 11:10 of 0xC8..0xCB
  localparam logic [1:0] LOW_REG_GROUP = 2'b10;   // bits 3:2 of 0x8..0xB

  // Function select, low two bits of the reg or imm opcode
  localparam logic [1:0] FN_TST = 2'd0;
  localparam logic [1:0] FN_AND = 2'd1;
  localparam logic [1:0] FN_XOR = 2'd2;
  localparam logic [1:0] FN_OR  = 2'd3;

  localparam logic [DATA_W-1:0] PC_STEP    = 32'd2;
  localparam logic [DATA_W-1:0] COST_BASE  = 32'd1;
  localparam logic [DATA_W-1:0] COST_OR_IMM = 32'd5;

  typedef struct packed {
    logic [1:0]           command;
    logic [15:0]          instr_word;
    logic [REG_IDX_W-1:0] reg_index;
    logic [DATA_W-1:0]    load_value;
  } cmd_item_t;

  typedef struct packed {
    logic                 en;
    logic [REG_IDX_W-1:0] a_idx;
    logic [REG_IDX_W-1:0] b_idx;
  } rf_rd_t;

  typedef struct packed {
    logic                 en;
    logic [REG_IDX_W-1:0] idx;
    logic [DATA_W-1:0]    data;
  } rf_wr_t;

  typedef struct packed {
    logic [DATA_W-1:0] pc;
    logic [DATA_W-1:0] cycles;
    logic              t;
  } arch_state_t;

  typedef struct packed {
    logic                 wr;
    logic [REG_IDX_W-1:0] idx;
    logic [DATA_W-1:0]    value;
    logic                 unknown;
    arch_state_t          state;
  } exec_res_t;

endpackage

// ===== rtl/lie_cmd_if.sv =====
// ----------------------------------------------------------------------------
// lie_cmd_if
// Command channel: valid/ready handshake with the command item payload.
// ----------------------------------------------------------------------------
interface lie_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] instr_word;
  logic [3:0]  reg_index;
  logic [31:0] load_value;

  modport source (output valid, command, instr_word, reg_index, load_value, input ready);
  modport sink   (input valid, command, instr_word, reg_index, load_value, output ready);
endinterface

// ===== rtl/lie_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lie_rsp_if
// Result channel: valid/ready handshake with the result item payload.
// ----------------------------------------------------------------------------
interface lie_rsp_if;
  logic        valid;
  logic        ready;
  logic        dest_written;
  logic [3:0]  dest_index;
  logic [31:0] dest_value;
  logic        t_bit;
  logic [31:0] pc_value;
  logic [31:0] cycle_total;
  logic        unknown_opcode;

  modport source (output valid, dest_written, dest_index, dest_value, t_bit, pc_value,
                  cycle_total, unknown_opcode, input ready);
  modport sink   (input valid, dest_written, dest_index, dest_value, t_bit, pc_value,
                  cycle_total, unknown_opcode, output ready);
endinterface

// ===== rtl/lie_regfile.sv =====
// ----------------------------------------------------------------------------
// lie_regfile
// General register memory, two registered read ports, one write port.
// ----------------------------------------------------------------------------
module lie_regfile
  import lie_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  rf_rd_t            rd,
  input  rf_wr_t            wr,
  output logic [DATA_W-1:0] a_data,
  output logic [DATA_W-1:0] b_data
);

  logic [DATA_W-1:0]   mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.data;
    end
  end

  // Unwritten entries read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr.idx] <= 1'b1;
    end
  end

  // Forward a same-edge write into the read data.
  always_ff @(posedge clk) begin
    if (rd.en) begin
      if (wr.en && wr.idx == rd.a_idx) begin
        a_data <= wr.data;
      end else begin
        a_data <= vld[rd.a_idx] ? mem[rd.a_idx] : '0;
      end
      if (wr.en && wr.idx == rd.b_idx) begin
        b_data <= wr.data;
      end else begin
        b_data <= vld[rd.b_idx] ? mem[rd.b_idx] : '0;
      end
    end
  end

endmodule

// ===== rtl/lie_exec.sv =====
// ----------------------------------------------------------------------------
// lie_exec
// Decode and logic unit: computes the register write, flag and counters.
// ----------------------------------------------------------------------------
module lie_exec
  import lie_pkg::*;
(
  input  cmd_item_t         item,
  input  logic [DATA_W-1:0] a_data,
  input  logic [DATA_W-1:0] b_data,
  input  arch_state_t       cur,
  output exec_res_t         res
);

  logic [3:0]        top_nib;
  logic [3:0]        low_nib;
  logic              is_reg_op;
  logic              is_not;
  logic              is_imm_op;
  logic [1:0]        fn;
  logic [DATA_W-1:0] opa;
  logic [DATA_W-1:0] opb;
  logic [DATA_W-1:0] alu;

  assign top_nib   = item.instr_word[15:12];
  assign low_nib   = item.instr_word[3:0];
  assign is_reg_op = (top_nib == TOP_REG_LOGIC) && (low_nib[3:2] == LOW_REG_GROUP);
  assign is_not    = (top_nib == TOP_NOT) && (low_nib == LOW_NOT);
  assign is_imm_op = (top_nib == TOP_IMM) && (item.instr_word[11:10] == HI_IMM_GROUP);
  assign fn        = is_imm_op ? item.instr_word[9:8] : low_nib[1:0];

  // Port A reads R0 for the immediate forms.
  assign opa = a_data;
  assign opb = is_imm_op ? {24'd0, item.instr_word[7:0]} : b_data;

  always_comb begin
    case (fn)
      FN_AND:  alu = opa & opb;
      FN_XOR:  alu = opa ^ opb;
      FN_OR:   alu = opa | opb;
      default: alu = opa & opb;
    endcase
  end

  always_comb begin
    res.wr      = 1'b0;
    res.idx     = '0;
    res.value   = '0;
    res.unknown = 1'b0;
    res.state   = cur;
    case (item.command)
      CMD_EXEC: begin
        if (is_not) begin
          res.wr    = 1'b1;
          res.idx   = item.instr_word[11:8];
          res.value = ~b_data;
        end else if (is_reg_op || is_imm_op) begin
          if (fn == FN_TST) begin
            res.state.t = (alu == '0);
          end else begin
            res.wr    = 1'b1;
            res.idx   = is_imm_op ? '0 : item.instr_word[11:8];
            res.value = alu;
          end
        end
        if (is_not || is_reg_op || is_imm_op) begin
          res.state.pc     = cur.pc + PC_STEP;
          res.state.cycles = cur.cycles +
                             ((is_imm_op && fn == FN_OR) ? COST_OR_IMM : COST_BASE);
        end else begin
          res.unknown = 1'b1;
        end
      end
      CMD_LOAD_REG: begin
        res.wr    = 1'b1;
        res.idx   = item.reg_index;
        res.value = item.load_value;
      end
      CMD_LOAD_PC: begin
        res.state.pc = item.load_value;
      end
      default: begin
        res.wr = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/logic_instruction_execute_top.sv =====
// ----------------------------------------------------------------------------
// logic_instruction_execute_top
// Logic-class instruction execute unit over a sixteen-entry register memory.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                            | accept
//  cmd     | in  | command, instr_word, reg_index, load_value         | valid & ready
//  rsp     | out | dest_written, dest_index, dest_value, t_bit,       | valid & ready
//          |     | pc_value, cycle_total, unknown_opcode              |
//
//  One item per cycle sustained while rsp.ready stays high. The accepting edge reads
//  Rn/Rm (or R0) into the register memory's read registers; once the result register
//  is free, the execute stage executes, writes back and loads the result register.
//  A write landing on the same edge as the next item's read is forwarded, so
//  dependent items run back to back.
//  Reset (rst, synchronous) clears valid bits of the register memory, T, PC,
//  the cycle counter and both pipeline valids; no clearing pass is needed.
//  cmd.ready stays low while rst is high.
//  A stalled result holds the execute stage, which in turn holds cmd.ready low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module logic_instruction_execute_top
  import lie_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  lie_cmd_if.sink  cmd,
  lie_rsp_if.source rsp
);

  // Execute stage
  logic        s1_valid;
  cmd_item_t   s1_item;
  logic        s1_adv;
  logic        s1_fire;
  logic        accept;

  // Architectural state outside the register memory
  arch_state_t cur;

  rf_rd_t            rf_rd;
  rf_wr_t            rf_wr;
  logic [DATA_W-1:0] a_data;
  logic [DATA_W-1:0] b_data;
  exec_res_t         res;

  // Advance execute whenever the result register is empty or being taken.
  assign s1_adv    = !rsp.valid || rsp.ready;
  assign s1_fire   = s1_valid && s1_adv;
  assign cmd.ready = !rst && (!s1_valid || s1_adv);
  assign accept    = cmd.valid && cmd.ready;

  // Issue reads straight from the incoming item; immediate forms use R0.
  assign rf_rd.en    = accept;
  assign rf_rd.a_idx = (cmd.instr_word[15:12] == TOP_IMM) ? '0 : cmd.instr_word[11:8];
  assign rf_rd.b_idx = cmd.instr_word[7:4];

  // Write back as the item leaves execute.
  assign rf_wr.en   = s1_fire && res.wr;
  assign rf_wr.idx  = res.idx;
  assign rf_wr.data = res.value;

  lie_regfile u_regfile (
    .clk    (clk),
    .rst    (rst),
    .rd     (rf_rd),
    .wr     (rf_wr),
    .a_data (a_data),
    .b_data (b_data)
  );

  lie_exec u_exec (
    .item   (s1_item),
    .a_data (a_data),
    .b_data (b_data),
    .cur    (cur),
    .res    (res)
  );

  // Capture the item alongside its read.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item.command    <= cmd.command;
      s1_item.instr_word <= cmd.instr_word;
      s1_item.reg_index  <= cmd.reg_index;
      s1_item.load_value <= cmd.load_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  // Commit T, PC and cycle count with the item.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
    end else if (s1_fire) begin
      cur <= res.state;
    end
  end

  // Result register: load on fire, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (s1_fire) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      rsp.dest_written   <= res.wr;
      rsp.dest_index     <= res.idx;
      rsp.dest_value     <= res.value;
      rsp.t_bit          <= res.state.t;
      rsp.pc_value       <= res.state.pc;
      rsp.cycle_total    <= res.state.cycles;
      rsp.unknown_opcode <= res.unknown;
    end
  end

  // A stalled execute stage keeps its item.
  `ASSERT_NEXT(a_s1_hold, s1_valid && !s1_adv, s1_valid)
  // Counters move only when an item leaves execute.
  `ASSERT_NEXT(a_state_quiet, !s1_fire, $stable(cur))
  // An unknown instruction never writes a register.
  `ASSERT_IMPL(a_unknown_no_write, s1_fire && res.unknown, !rf_wr.en)
  // A freshly loaded result reflects the committed PC and cycle count.
  `ASSERT_NEXT(a_rsp_matches_state, s1_fire,
               rsp.valid && rsp.pc_value == cur.pc && rsp.cycle_total == cur.cycles)

endmodule

// ===== bench/logic_instruction_execute_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// logic_instruction_execute_top_test
// Self-checking bench for the logic instruction execute unit. A directed
// table covers the reset state, field extremes, every logic op, unknown
// words and the load commands. A random run follows, half of it well-formed
// logic ops on a live register file. Both channel ends idle at random, and
// one long receiver hold-off backs the pipe up into the command channel.
// ----------------------------------------------------------------------------
module logic_instruction_execute_top_test;
  import lie_pkg::*;

  // Command code 3 is not defined; the block must ignore it.
  localparam logic [1:0] CMD_UNDEF = 2'd3;

  localparam int RANDOM_ITEMS    = 1000;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int HOLD_OFF_AT     = 300;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int REPORT_MAX      = 10;

  // One result item, in the order of the result channel fields.
  typedef struct packed {
    logic                 dest_written;
    logic [REG_IDX_W-1:0] dest_index;
    logic [DATA_W-1:0]    dest_value;
    logic                 t_bit;
    logic [DATA_W-1:0]    pc_value;
    logic [DATA_W-1:0]    cycle_total;
    logic                 unknown_opcode;
  } result_t;

  // A row of the directed table: the command, and its result where it is
  // typed in by hand (typed = 1); other rows take the predicted result.
  typedef struct packed {
    cmd_item_t item;
    logic      typed;
    result_t   res;
  } directed_row_t;

  localparam result_t NO_RES = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lie_cmd_if cmd_ch ();
  lie_rsp_if rsp_ch ();

  logic_instruction_execute_top u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Architectural state as the bench sees it
  // --------------------------------------------------------------------------
  logic [DATA_W-1:0] gpr [NUM_REGS];
  logic              t_flag;
  logic [DATA_W-1:0] pc_reg;
  logic [DATA_W-1:0] cycle_cnt;

  result_t pending_results [$];

  int  cmds_sent;
  int  results_seen;
  int  mismatch_count;
  int  exec_count;
  int  unknown_count;
  int  load_count;
  int  cycle_count;
  bit  send_calm;
  bit  recv_calm;

  // Apply one command to the bench state and return the result it yields.
  function automatic result_t execute_logic_cmd(input cmd_item_t it);
    result_t              r;
    logic [3:0]           n, m, top, low;
    logic [7:0]           imm;
    logic [1:0]           fn;
    logic [DATA_W-1:0]    a, b, val, cost;
    logic [REG_IDX_W-1:0] dst;
    logic                 decoded, wr, is_not;
    r       = '0;
    top     = it.instr_word[15:12];
    n       = it.instr_word[11:8];
    m       = it.instr_word[7:4];
    low     = it.instr_word[3:0];
    imm     = it.instr_word[7:0];
    a       = '0;
    b       = '0;
    val     = '0;
    fn      = FN_AND;
    dst     = n;
    cost    = COST_BASE;
    decoded = 1'b1;
    wr      = 1'b1;
    is_not  = (top == TOP_NOT) && (low == LOW_NOT);
    case (it.command)
      CMD_EXEC: begin
        if (top == TOP_REG_LOGIC && low[3:2] == LOW_REG_GROUP) begin
          // Rn op= Rm
          a  = gpr[n];
          b  = gpr[m];
          fn = low[1:0];
        end else if (top == TOP_IMM && it.instr_word[11:10] == HI_IMM_GROUP) begin
          // R0 op= zero-extended immediate; OR #imm costs extra cycles
          a   = gpr[0];
          b   = {{(DATA_W-8){1'b0}}, imm};
          fn  = it.instr_word[9:8];
          dst = '0;
          if (fn == FN_OR) cost = COST_OR_IMM;
        end else if (!is_not) begin
          decoded = 1'b0;
        end
        if (decoded) begin
          if (is_not) begin
            val = ~gpr[m];
          end else begin
            case (fn)
              FN_TST: begin
                t_flag = ((a & b) == '0);
                wr     = 1'b0;
              end
              FN_AND:  val = a & b;
              FN_XOR:  val = a ^ b;
              default: val = a | b;
            endcase
          end
          if (wr) begin
            gpr[dst]       = val;
            r.dest_written = 1'b1;
            r.dest_index   = dst;
            r.dest_value   = val;
          end
          pc_reg    = pc_reg + PC_STEP;
          cycle_cnt = cycle_cnt + cost;
        end
        r.unknown_opcode = !decoded;
      end
      CMD_LOAD_REG: begin
        gpr[it.reg_index] = it.load_value;
        r.dest_written    = 1'b1;
        r.dest_index      = it.reg_index;
        r.dest_value      = it.load_value;
      end
      CMD_LOAD_PC: pc_reg = it.load_value;
      default: ;
    endcase
    r.t_bit       = t_flag;
    r.pc_value    = pc_reg;
    r.cycle_total = cycle_cnt;
    return r;
  endfunction

  // Offer one command after a random gap, hold it until accepted, then
  // queue its expected result.
  task automatic offer_cmd(input cmd_item_t it, input logic typed, input result_t typed_res);
    int      gap;
    result_t predicted;
    gap = send_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.command    <= it.command;
    cmd_ch.instr_word <= it.instr_word;
    cmd_ch.reg_index  <= it.reg_index;
    cmd_ch.load_value <= it.load_value;
    do @(posedge clk); while (!cmd_ch.ready);
    predicted = execute_logic_cmd(it);
    pending_results.push_back(typed ? typed_res : predicted);
    cmds_sent++;
    if (it.command == CMD_EXEC) begin
      if (predicted.unknown_opcode) unknown_count++;
      else exec_count++;
    end else if (it.command != CMD_UNDEF) begin
      load_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus: reset, directed table, random commands, drain, verdict
  // --------------------------------------------------------------------------
  initial begin : stimulus
    directed_row_t dir_tab [$];
    cmd_item_t     it;
    int            sel;
    logic [1:0]    fn;
    logic [3:0]    n, m;
    logic [7:0]    imm;

    cmd_ch.valid      <= 1'b0;
    cmd_ch.command    <= CMD_EXEC;
    cmd_ch.instr_word <= '0;
    cmd_ch.reg_index  <= '0;
    cmd_ch.load_value <= '0;
    for (int i = 0; i < NUM_REGS; i++) gpr[i] = '0;
    t_flag         = 1'b0;
    pc_reg         = '0;
    cycle_cnt      = '0;
    cmds_sent      = 0;
    exec_count     = 0;
    unknown_count  = 0;
    load_count     = 0;
    send_calm      = 1'b0;

    // Hold reset, then release it.
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Rows straight out of reset carry hand-typed results.
    // TST #0,R0 on a cleared R0 sets T.
    dir_tab.push_back('{'{CMD_EXEC, 16'hC800, 4'h0, 32'h0}, 1'b1,
                        '{1'b0, 4'h0, 32'h0, 1'b1, 32'h2, 32'h1, 1'b0}});
    // All-zero and all-one words decode to nothing; state holds.
    dir_tab.push_back('{'{CMD_EXEC, 16'h0000, 4'h0, 32'h0}, 1'b1,
                        '{1'b0, 4'h0, 32'h0, 1'b1, 32'h2, 32'h1, 1'b1}});
    dir_tab.push_back('{'{CMD_EXEC, 16'hFFFF, 4'hF, 32'hFFFF_FFFF}, 1'b1,
                        '{1'b0, 4'h0, 32'h0, 1'b1, 32'h2, 32'h1, 1'b1}});
    // Undefined command with every payload bit set: ignored.
    dir_tab.push_back('{'{CMD_UNDEF, 16'hFFFF, 4'hF, 32'hFFFF_FFFF}, 1'b1,
                        '{1'b0, 4'h0, 32'h0, 1'b1, 32'h2, 32'h1, 1'b0}});
    // Register loads at both index and value extremes.
    dir_tab.push_back('{'{CMD_LOAD_REG, 16'h0000, 4'h0, 32'hFFFF_FFFF}, 1'b1,
                        '{1'b1, 4'h0, 32'hFFFF_FFFF, 1'b1, 32'h2, 32'h1, 1'b0}});
    dir_tab.push_back('{'{CMD_LOAD_REG, 16'hFFFF, 4'hF, 32'h0}, 1'b1,
                        '{1'b1, 4'hF, 32'h0, 1'b1, 32'h2, 32'h1, 1'b0}});
    // Park PC just below the wrap point.
    dir_tab.push_back('{'{CMD_LOAD_PC, 16'h0000, 4'h0, 32'hFFFF_FFFE}, 1'b1,
                        '{1'b0, 4'h0, 32'h0, 1'b1, 32'hFFFF_FFFE, 32'h1, 1'b0}});
    // OR #0xFF,R0 wraps PC to zero and adds five to the cycle total.
    dir_tab.push_back('{'{CMD_EXEC, 16'hCBFF, 4'h0, 32'h0}, 1'b1,
                        '{1'b1, 4'h0, 32'hFFFF_FFFF, 1'b1, 32'h0, 32'h6, 1'b0}});
    // TST #0xFF,R0 on a nonzero R0 clears T.
    dir_tab.push_back('{'{CMD_EXEC, 16'hC8FF, 4'h0, 32'h0}, 1'b1,
                        '{1'b0, 4'h0, 32'h0, 1'b0, 32'h2, 32'h7, 1'b0}});

    // The rest go through the predictor.
    dir_tab.push_back('{'{CMD_LOAD_REG, 16'h0, 4'h1, 32'hA5A5_A5A5}, 1'b0, NO_RES});
    dir_tab.push_back('{'{CMD_LOAD_REG, 16'h0, 4'h2, 32'h5A5A_5A5A}, 1'b0, NO_RES});
    dir_tab.push_back('{'{CMD_EXEC, 16'h2219, 4'h0, 32'h0}, 1'b0, NO_RES});  // AND R1,R2
    dir_tab.push_back('{'{CMD_EXEC, 16'h2108, 4'h0, 32'h0}, 1'b0, NO_RES});  // TST R0,R1
    dir_tab.push_back('{'{CMD_EXEC, 16'h2F28, 4'h0, 32'h0}, 1'b0, NO_RES});  // TST R2,R15
    dir_tab.push_back('{'{CMD_EXEC, 16'h212A, 4'h0, 32'h0}, 1'b0, NO_RES});  // XOR R2,R1
    dir_tab.push_back('{'{CMD_EXEC, 16'h210B, 4'h0, 32'h0}, 1'b0, NO_RES});  // OR R0,R1
    dir_tab.push_back('{'{CMD_EXEC, 16'h6F07, 4'h0, 32'h0}, 1'b0, NO_RES});  // NOT R0,R15
    dir_tab.push_back('{'{CMD_EXEC, 16'hC955, 4'h0, 32'h0}, 1'b0, NO_RES});  // AND #imm
    dir_tab.push_back('{'{CMD_EXEC, 16'hCAAA, 4'h0, 32'h0}, 1'b0, NO_RES});  // XOR #imm
    dir_tab.push_back('{'{CMD_EXEC, 16'h401B, 4'h0, 32'h0}, 1'b0, NO_RES});  // TAS.B
    dir_tab.push_back('{'{CMD_EXEC, 16'h2007, 4'h0, 32'h0}, 1'b0, NO_RES});  // near misses
    dir_tab.push_back('{'{CMD_EXEC, 16'h6F06, 4'h0, 32'h0}, 1'b0, NO_RES});
    dir_tab.push_back('{'{CMD_EXEC, 16'hC7FF, 4'h0, 32'h0}, 1'b0, NO_RES});
    dir_tab.push_back('{'{CMD_EXEC, 16'hCC00, 4'h0, 32'h0}, 1'b0, NO_RES});

    foreach (dir_tab[i]) offer_cmd(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].res);

    // Random part: half well-formed logic ops, the rest raw words, loads
    // and the odd undefined command.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // Switch between idling and back-to-back stretches now and then.
      if (i % 50 == 0) send_calm = ($urandom_range(0, 2) == 0);
      sel  = $urandom_range(0, 99);
      fn   = 2'($urandom_range(0, 3));
      n    = 4'($urandom_range(0, 15));
      m    = 4'($urandom_range(0, 15));
      imm  = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
      it.command    = CMD_EXEC;
      it.instr_word = 16'($urandom);
      it.reg_index  = 4'($urandom);
      it.load_value = $urandom;
      if (sel < 50) begin
        case ($urandom_range(0, 2))
          0:       it.instr_word = {TOP_REG_LOGIC, n, m, LOW_REG_GROUP, fn};
          1:       it.instr_word = {TOP_NOT, n, m, LOW_NOT};
          default: it.instr_word = {TOP_IMM, HI_IMM_GROUP, fn, imm};
        endcase
      end else if (sel < 65) begin
        // keep the raw word
      end else if (sel < 88) begin
        it.command = CMD_LOAD_REG;
        // Sparse values give TST a fair chance of a zero AND.
        if ($urandom_range(0, 2) == 0) it.load_value = $urandom & $urandom & $urandom;
      end else if (sel < 95) begin
        it.command = CMD_LOAD_PC;
        // Land close to the wrap point half the time.
        if ($urandom_range(0, 1) == 0) it.load_value = 32'hFFFF_FFF0 | ($urandom & 32'hF);
      end else begin
        it.command = CMD_UNDEF;
      end
      offer_cmd(it, 1'b0, NO_RES);
    end
    cmd_ch.valid <= 1'b0;

    // Drain: wait for every result, then a few more cycles for strays.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d commands: %0d logic ops, %0d unknown words, %0d loads.",
             cmds_sent, exec_count, unknown_count, load_count);
    $display("Checked %0d results with %0d mismatching, %0d still outstanding.",
             results_seen, mismatch_count, pending_results.size());
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random stalls, one long hold-off, check against the queue
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int      stall;
    bit      held;
    result_t got;
    result_t want;
    held           = 1'b0;
    results_seen   = 0;
    mismatch_count = 0;
    recv_calm      = 1'b0;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (results_seen % 50 == 0) recv_calm = ($urandom_range(0, 2) == 0);
      // Hold off once for a long stretch so the pipe fills and stalls cmd.
      if (!held && results_seen == HOLD_OFF_AT) begin
        held  = 1'b1;
        stall = HOLD_OFF_CYCLES;
      end else begin
        stall = recv_calm ? 0 : $urandom_range(0, 7);
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      got = '{rsp_ch.dest_written, rsp_ch.dest_index, rsp_ch.dest_value, rsp_ch.t_bit,
              rsp_ch.pc_value, rsp_ch.cycle_total, rsp_ch.unknown_opcode};
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("Result %0d arrived with nothing expected", results_seen);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("Result %0d exp: wr=%0d idx=%0d val=%h t=%0d pc=%h cyc=%h unk=%0d",
                     results_seen, want.dest_written, want.dest_index, want.dest_value,
                     want.t_bit, want.pc_value, want.cycle_total, want.unknown_opcode);
            $display("Result %0d got: wr=%0d idx=%0d val=%h t=%0d pc=%h cyc=%h unk=%0d",
                     results_seen, got.dest_written, got.dest_index, got.dest_value,
                     got.t_bit, got.pc_value, got.cycle_total, got.unknown_opcode);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: drop the run if it hangs
  // --------------------------------------------------------------------------
  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_results.size());
      $display("Verification failed");
      $finish;
    end
  end

endmodule
